// ===== design/ppp_pkg.sv =====
// shared widths, register indexes and types of the pinhole point projector
// no dependencies
`default_nettype none

package ppp_pkg;

  localparam int IMAGE_WIDTH_DEF  = 1300;
  localparam int IMAGE_HEIGHT_DEF = 800;

  localparam int QW  = 16;  // quaternion component, Q1.14
  localparam int EW  = 35;  // rotation entry before rounding, Q28
  localparam int RW  = 30;  // rotation entry, Q24
  localparam int DW  = 33;  // world point minus camera position, Q16.16
  localparam int PW  = 63;  // rotation times difference, Q40
  localparam int SW  = 64;  // sum of three products, Q40
  localparam int CW  = 40;  // camera coordinate, Q16
  localparam int UPW = 57;  // focal or center times coordinate
  localparam int UW  = 56;  // projected u, v in Q20
  localparam int NW  = 57;  // divider numerator
  localparam int DNW = 41;  // divider denominator

  localparam int IDXW = 3;
  localparam int CFGW = 64;

  localparam logic [IDXW-1:0] REG_FOCAL_X  = 3'd0;
  localparam logic [IDXW-1:0] REG_FOCAL_Y  = 3'd1;
  localparam logic [IDXW-1:0] REG_CENTER_X = 3'd2;
  localparam logic [IDXW-1:0] REG_CENTER_Y = 3'd3;
  localparam logic [IDXW-1:0] REG_ROTATION = 3'd4;
  localparam logic [IDXW-1:0] REG_POSITION = 3'd5;

  localparam logic [15:0] FOCAL_X_RST  = 16'd6400;
  localparam logic [15:0] FOCAL_Y_RST  = 16'd6400;
  localparam logic [15:0] CENTER_X_RST = 16'd3040;
  localparam logic [15:0] CENTER_Y_RST = 16'd2560;
  localparam logic [63:0] ROTATION_RST = 64'hE000_2000_2000_E000;
  localparam logic [47:0] POSITION_RST = 48'h0200_0200_0200;

  typedef logic signed [RW-1:0] rot_elem_t;
  typedef rot_elem_t [8:0] rot_mat_t;  // row-major, r[row*3+col]

endpackage

`default_nettype wire

// ===== design/ppp_rot.sv =====
// rotation matrix of the configured quaternion, two register stages
// depends on ppp_pkg
`default_nettype none

module ppp_rot (
  input  wire logic                  clk,
  input  wire logic [63:0]           camera_rotation,
  output ppp_pkg::rot_mat_t          rot
);

  logic signed [ppp_pkg::QW-1:0] qw, qx, qy, qz;
  logic signed [2*ppp_pkg::QW-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic signed [ppp_pkg::EW-1:0] e [9];
  logic signed [ppp_pkg::EW-1:0] one;

  assign qw  = camera_rotation[63:48];
  assign qx  = camera_rotation[47:32];
  assign qy  = camera_rotation[31:16];
  assign qz  = camera_rotation[15:0];
  assign one = ppp_pkg::EW'(64'sd1 <<< 28);

  always_ff @(posedge clk) begin
    xx <= qx * qx;
    yy <= qy * qy;
    zz <= qz * qz;
    xy <= qx * qy;
    xz <= qx * qz;
    yz <= qy * qz;
    wx <= qw * qx;
    wy <= qw * qy;
    wz <= qw * qz;
  end

  always_comb begin
    e[0] = one - 2 * (ppp_pkg::EW'(yy) + ppp_pkg::EW'(zz));
    e[1] = 2 * (ppp_pkg::EW'(xy) - ppp_pkg::EW'(wz));
    e[2] = 2 * (ppp_pkg::EW'(xz) + ppp_pkg::EW'(wy));
    e[3] = 2 * (ppp_pkg::EW'(xy) + ppp_pkg::EW'(wz));
    e[4] = one - 2 * (ppp_pkg::EW'(xx) + ppp_pkg::EW'(zz));
    e[5] = 2 * (ppp_pkg::EW'(yz) - ppp_pkg::EW'(wx));
    e[6] = 2 * (ppp_pkg::EW'(xz) - ppp_pkg::EW'(wy));
    e[7] = 2 * (ppp_pkg::EW'(yz) + ppp_pkg::EW'(wx));
    e[8] = one - 2 * (ppp_pkg::EW'(xx) + ppp_pkg::EW'(yy));
  end

  // round Q28 to Q24, ties upward
  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      rot[k] <= ppp_pkg::RW'((e[k] + ppp_pkg::EW'(8)) >>> 4);
    end
  end

endmodule

`default_nettype wire

// ===== design/ppp_div.sv =====
// pipelined restoring divider, one quotient bit per stage
// depends on nothing but its parameters
`default_nettype none

module ppp_div #(
  parameter int NW = 57,
  parameter int DNW = 41,
  parameter int QB = 15
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire logic [NW-1:0]  num,
  input  wire logic [DNW-1:0] den,
  output logic [QB-1:0]       quo
);

  localparam int XW = NW + QB;

  logic [NW-1:0]  rem_s [QB+1];
  logic [DNW-1:0] den_s [QB+1];
  logic [QB-1:0]  quo_s [QB+1];

  assign rem_s[0] = num;
  assign den_s[0] = den;
  assign quo_s[0] = '0;
  assign quo      = quo_s[QB];

  for (genvar g = 0; g < QB; g++) begin : g_stage
    localparam int B = QB - 1 - g;
    logic [XW-1:0] dsh;
    logic [XW-1:0] rx;
    logic          ge;

    assign dsh = XW'(den_s[g]) << B;
    assign rx  = XW'(rem_s[g]);
    assign ge  = rx >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[g+1] <= ge ? NW'(rx - dsh) : rem_s[g];
        den_s[g+1] <= den_s[g];
        quo_s[g+1] <= quo_s[g] | (QB'(ge) << B);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/pinhole_point_projector_core.sv =====
// Pinhole point projector: world point in Q16.16 to in-view flag and pixel offset in signed Q10.4 (x), Q9.4 (y).
// Takes one beat per cycle while the output is not stalled; the one-bit-per-stage quotient pipeline gives
// QB = clog2(16*max(width,height)+1) quotient bits. A stalled output holds the whole pipeline.
// Rotation is rebuilt from the register after a write, through the product and rounding registers of
// ppp_rot. Depends on ppp_pkg, ppp_rot and ppp_div.
`default_nettype none

module pinhole_point_projector_core #(
  parameter int IMAGE_WIDTH  = ppp_pkg::IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = ppp_pkg::IMAGE_HEIGHT_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [95:0]               s_axis_tdata,  // point_x, point_y, point_z
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic [31:0]                    m_axis_tdata,  // offset_x, offset_y, zero pad
  output logic                           m_axis_tuser,  // in_view
  input  wire logic                      cfg_we,
  input  wire logic [ppp_pkg::IDXW-1:0]  cfg_index,
  input  wire logic [ppp_pkg::CFGW-1:0]  cfg_data
);

  localparam int MAXD   = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
  localparam int QB     = $clog2(MAXD * 16 + 1);
  localparam int NST    = 8 + QB;
  localparam int HALF_X = (IMAGE_WIDTH / 2) * 16;
  localparam int HALF_Y = (IMAGE_HEIGHT / 2) * 16;

  logic [15:0] focal_x, focal_y, center_x, center_y;
  logic [63:0] camera_rotation;
  logic [47:0] camera_position;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x         <= ppp_pkg::FOCAL_X_RST;
      focal_y         <= ppp_pkg::FOCAL_Y_RST;
      center_x        <= ppp_pkg::CENTER_X_RST;
      center_y        <= ppp_pkg::CENTER_Y_RST;
      camera_rotation <= ppp_pkg::ROTATION_RST;
      camera_position <= ppp_pkg::POSITION_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ppp_pkg::REG_FOCAL_X:  focal_x         <= cfg_data[15:0];
        ppp_pkg::REG_FOCAL_Y:  focal_y         <= cfg_data[15:0];
        ppp_pkg::REG_CENTER_X: center_x        <= cfg_data[15:0];
        ppp_pkg::REG_CENTER_Y: center_y        <= cfg_data[15:0];
        ppp_pkg::REG_ROTATION: camera_rotation <= cfg_data;
        ppp_pkg::REG_POSITION: camera_position <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  ppp_pkg::rot_mat_t rot;

  ppp_rot u_rot (
    .clk             (clk),
    .camera_rotation (camera_rotation),
    .rot             (rot)
  );

  logic en;
  logic [NST-1:0] vld;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], s_axis_tvalid};
    end
  end

  assign m_axis_tvalid = vld[NST-1];

  // stage 0: input
  logic signed [31:0] p0 [3];
  // stage 1: difference
  logic signed [ppp_pkg::DW-1:0] d1 [3];
  // stage 2: rotation products, index camera axis * 3 + world axis
  logic signed [ppp_pkg::PW-1:0] m2 [9];
  // stage 3: camera coordinates
  logic signed [ppp_pkg::CW-1:0] c3 [3];
  // stage 4: projection products
  logic signed [ppp_pkg::UPW-1:0] fxc, cxc, fyc, cyc;
  logic signed [ppp_pkg::CW-1:0] w4;
  // stage 5: u, v, w with positive depth
  logic signed [ppp_pkg::UW-1:0] u5, v5;
  logic [ppp_pkg::CW-1:0] w5;
  // stage 6: bounds and divider operands
  logic view6;
  logic [ppp_pkg::NW-1:0] nx6, ny6;
  logic [ppp_pkg::DNW-1:0] den6;

  logic signed [ppp_pkg::SW-1:0] s3 [3];
  logic signed [ppp_pkg::UW-1:0] us, vs;
  logic [63:0] limx, limy;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s3[i] = ppp_pkg::SW'(m2[3*i]) + ppp_pkg::SW'(m2[3*i+1]) + ppp_pkg::SW'(m2[3*i+2]);
    end
    us   = ppp_pkg::UW'(fxc) + ppp_pkg::UW'(cxc);
    vs   = ppp_pkg::UW'(fyc) + ppp_pkg::UW'(cyc);
    limx = 64'(w5) * 64'(IMAGE_WIDTH * 16);
    limy = 64'(w5) * 64'(IMAGE_HEIGHT * 16);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0[0] <= s_axis_tdata[31:0];
      p0[1] <= s_axis_tdata[63:32];
      p0[2] <= s_axis_tdata[95:64];

      for (int i = 0; i < 3; i++) begin
        d1[i] <= ppp_pkg::DW'(p0[i]) -
                 (ppp_pkg::DW'($signed(camera_position[32-16*i +: 16])) <<< 8);
      end

      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          m2[3*i+j] <= rot[3*j+i] * d1[j];
        end
      end

      for (int i = 0; i < 3; i++) begin
        c3[i] <= ppp_pkg::CW'((s3[i] + ppp_pkg::SW'(64'sd1 <<< 23)) >>> 24);
      end

      fxc <= $signed({1'b0, focal_x}) * c3[0];
      cxc <= $signed({1'b0, center_x}) * c3[2];
      fyc <= $signed({1'b0, focal_y}) * c3[1];
      cyc <= $signed({1'b0, center_y}) * c3[2];
      w4  <= c3[2];

      u5 <= w4[ppp_pkg::CW-1] ? -us : us;
      v5 <= w4[ppp_pkg::CW-1] ? -vs : vs;
      w5 <= w4[ppp_pkg::CW-1] ? ppp_pkg::CW'(-w4) : ppp_pkg::CW'(w4);

      view6 <= (w5 != '0) && !u5[ppp_pkg::UW-1] && !v5[ppp_pkg::UW-1] &&
               (64'(u5) <= limx) && (64'(v5) <= limy);
      nx6   <= (ppp_pkg::NW'(u5) << 1) + ppp_pkg::NW'(w5);
      ny6   <= (ppp_pkg::NW'(v5) << 1) + ppp_pkg::NW'(w5);
      den6  <= {w5, 1'b0};
    end
  end

  logic [QB-1:0] qx, qy;

  ppp_div #(.NW(ppp_pkg::NW), .DNW(ppp_pkg::DNW), .QB(QB)) u_div_x (
    .clk (clk),
    .en  (en),
    .num (nx6),
    .den (den6),
    .quo (qx)
  );

  ppp_div #(.NW(ppp_pkg::NW), .DNW(ppp_pkg::DNW), .QB(QB)) u_div_y (
    .clk (clk),
    .en  (en),
    .num (ny6),
    .den (den6),
    .quo (qy)
  );

  logic [QB-1:0] view_d;

  always_ff @(posedge clk) begin
    if (en) begin
      view_d <= {view_d[QB-2:0], view6};
    end
  end

  logic signed [31:0] ox, oy;

  assign ox = 32'(qx) - 32'(HALF_X);
  assign oy = 32'(qy) - 32'(HALF_Y);

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tuser <= view_d[QB-1];
      m_axis_tdata <= view_d[QB-1] ? {3'b000, oy[13:0], ox[14:0]} : '0;
    end
  end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for pinhole_point_projector_core: world points in, pixel offsets out
// predicts results by its own fixed-point model or typed rows, checks beat by beat in order
// depends on ppp_pkg and the core with its submodules
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint IMG_W = 1300;
  localparam longint IMG_H = 800;

  typedef struct packed {
    logic        in_view;
    logic [14:0] offset_x;
    logic [13:0] offset_y;
  } pixel_t;

  typedef struct {
    logic [31:0] x, y, z;
    bit          typed;
    pixel_t      want;
  } point_row_t;

  logic                         clk, rst;
  logic                         s_axis_tvalid, s_axis_tready;
  logic [95:0]                  s_axis_tdata;
  logic                         m_axis_tvalid, m_axis_tready;
  logic [31:0]                  m_axis_tdata;
  logic                         m_axis_tuser;
  logic                         cfg_we;
  logic [ppp_pkg::IDXW-1:0]     cfg_index;
  logic [ppp_pkg::CFGW-1:0]     cfg_data;

  pinhole_point_projector_core u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  logic [15:0] fx_q, fy_q, cx_q, cy_q;
  logic [63:0] rot_q;
  logic [47:0] pos_q;

  pixel_t pending_pixels[$];
  int     errors;
  int     burst_left;
  bit     gaps_on;
  bit     hold_req;
  int     hold_left;
  int     mode_left;
  int     rx_mode;

  function automatic pixel_t project_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    longint q[4];
    longint r[9];
    longint d[3];
    longint c[3];
    longint one, u, v, w, s, ox, oy;
    logic [31:0] p[3];
    pixel_t res;
    one = 64'sd1 <<< 28;
    p[0] = px; p[1] = py; p[2] = pz;
    for (int i = 0; i < 4; i++) q[i] = longint'($signed(rot_q[63-16*i -: 16]));
    r[0] = one - 2 * (q[2] * q[2] + q[3] * q[3]);
    r[1] = 2 * (q[1] * q[2] - q[0] * q[3]);
    r[2] = 2 * (q[1] * q[3] + q[0] * q[2]);
    r[3] = 2 * (q[1] * q[2] + q[0] * q[3]);
    r[4] = one - 2 * (q[1] * q[1] + q[3] * q[3]);
    r[5] = 2 * (q[2] * q[3] - q[0] * q[1]);
    r[6] = 2 * (q[1] * q[3] - q[0] * q[2]);
    r[7] = 2 * (q[2] * q[3] + q[0] * q[1]);
    r[8] = one - 2 * (q[1] * q[1] + q[2] * q[2]);
    for (int i = 0; i < 9; i++) r[i] = (r[i] + 8) >>> 4;
    for (int i = 0; i < 3; i++)
      d[i] = longint'($signed(p[i])) - longint'($signed(pos_q[47-16*i -: 16])) * 256;
    for (int i = 0; i < 3; i++) begin
      s = r[i] * d[0] + r[3+i] * d[1] + r[6+i] * d[2];
      c[i] = (s + (64'sd1 <<< 23)) >>> 24;
    end
    u = longint'(fx_q) * c[0] + longint'(cx_q) * c[2];
    v = longint'(fy_q) * c[1] + longint'(cy_q) * c[2];
    w = c[2];
    if (w < 0) begin
      u = -u; v = -v; w = -w;
    end
    res = '0;
    if (w != 0 && u >= 0 && v >= 0 && u <= IMG_W * 16 * w && v <= IMG_H * 16 * w) begin
      ox = (2 * u + w) / (2 * w) - (IMG_W / 2) * 16;
      oy = (2 * v + w) / (2 * w) - (IMG_H / 2) * 16;
      res.in_view  = 1'b1;
      res.offset_x = ox[14:0];
      res.offset_y = oy[13:0];
    end
    return res;
  endfunction

  task automatic write_reg(logic [ppp_pkg::IDXW-1:0] idx, logic [ppp_pkg::CFGW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      ppp_pkg::REG_FOCAL_X:  fx_q  = val[15:0];
      ppp_pkg::REG_FOCAL_Y:  fy_q  = val[15:0];
      ppp_pkg::REG_CENTER_X: cx_q  = val[15:0];
      ppp_pkg::REG_CENTER_Y: cy_q  = val[15:0];
      ppp_pkg::REG_ROTATION: rot_q = val;
      ppp_pkg::REG_POSITION: pos_q = val[47:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_camera(logic [15:0] fx, logic [15:0] fy, logic [15:0] cx, logic [15:0] cy,
                             logic [63:0] rot, logic [47:0] pos);
    write_reg(ppp_pkg::REG_FOCAL_X, 64'(fx));
    write_reg(ppp_pkg::REG_FOCAL_Y, 64'(fy));
    write_reg(ppp_pkg::REG_CENTER_X, 64'(cx));
    write_reg(ppp_pkg::REG_CENTER_Y, 64'(cy));
    write_reg(ppp_pkg::REG_ROTATION, rot);
    write_reg(ppp_pkg::REG_POSITION, 64'(pos));
    cfg_we <= 1'b0;
    repeat (4) @(posedge clk);
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            bit typed, pixel_t want);
    bit hs;
    pixel_t exp_pix;
    if (burst_left == 0) begin
      if (gaps_on) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x};
    do begin
      @(negedge clk);
      hs = s_axis_tready;
      @(posedge clk);
    end while (!hs);
    exp_pix = typed ? want : project_point(x, y, z);
    pending_pixels = {pending_pixels, exp_pix};
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] random_coord(logic [15:0] cam);
    longint base;
    longint off;
    base = longint'($signed(cam)) * 256;
    off  = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
    if ($urandom_range(0, 3) == 0) return $urandom;
    return 32'(base + off);
  endfunction

  task automatic random_points(int n);
    for (int i = 0; i < n; i++)
      send_point(random_coord(pos_q[47:32]), random_coord(pos_q[31:16]),
                 random_coord(pos_q[15:0]), 1'b0, '0);
  endtask

  function automatic logic [63:0] random_quat();
    logic [63:0] qv;
    for (int i = 0; i < 4; i++)
      qv[16*i +: 16] = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 32768) - 16384);
    return qv;
  endfunction

  // receiver: changing stall pattern plus one long hold
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
      end
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= $urandom_range(0, 1);
          default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(negedge clk) begin
    pixel_t got, exp_pix;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.in_view  = m_axis_tuser;
      got.offset_x = m_axis_tdata[14:0];
      got.offset_y = m_axis_tdata[28:15];
      if (pending_pixels.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        exp_pix = pending_pixels.pop_front();
        if (got.in_view !== exp_pix.in_view) begin
          $error("in_view: expected %0d, got %0d", exp_pix.in_view, got.in_view);
          errors++;
        end
        if (got.offset_x !== exp_pix.offset_x) begin
          $error("offset_x: expected %0d, got %0d", $signed(exp_pix.offset_x),
                 $signed(got.offset_x));
          errors++;
        end
        if (got.offset_y !== exp_pix.offset_y) begin
          $error("offset_y: expected %0d, got %0d", $signed(exp_pix.offset_y),
                 $signed(got.offset_y));
          errors++;
        end
      end
    end
  end

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    point_row_t rows [16];
    errors = 0; burst_left = 0; gaps_on = 1'b1; hold_req = 1'b0; hold_left = 0;
    mode_left = 0; rx_mode = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    fx_q = ppp_pkg::FOCAL_X_RST; fy_q = ppp_pkg::FOCAL_Y_RST;
    cx_q = ppp_pkg::CENTER_X_RST; cy_q = ppp_pkg::CENTER_Y_RST;
    rot_q = ppp_pkg::ROTATION_RST; pos_q = ppp_pkg::POSITION_RST;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    repeat (4) @(posedge clk);

    rows = '{
      // point on the camera centre: zero depth
      '{32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 1'b1, '0},
      '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0},
      '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, '0},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0, '0},
      '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0},
      '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
      // a step of five units from the camera along each axis, in front and behind
      '{32'h0007_0000, 32'h0002_0000, 32'h0002_0000, 1'b0, '0},
      '{32'hFFFD_0000, 32'h0002_0000, 32'h0002_0000, 1'b0, '0},
      '{32'h0002_0000, 32'h0007_0000, 32'h0002_0000, 1'b0, '0},
      '{32'h0002_0000, 32'hFFFD_0000, 32'h0002_0000, 1'b0, '0},
      '{32'h0002_0000, 32'h0002_0000, 32'h0007_0000, 1'b0, '0},
      '{32'h0002_0000, 32'h0002_0000, 32'hFFFD_0000, 1'b0, '0},
      '{32'h0003_8000, 32'h0001_8000, 32'h0012_0000, 1'b0, '0},
      '{32'hFFF0_0000, 32'h0002_4000, 32'h0002_1000, 1'b0, '0}
    };
    foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].z, rows[i].typed, rows[i].want);
    random_points(40);
    drain();

    load_camera('0, '0, '0, '0, '0, '0);
    random_points(60);
    drain();

    load_camera('1, '1, '1, '1, '1, '1);
    random_points(60);
    drain();

    // identity camera at the origin, receiver held off while points keep coming
    load_camera(ppp_pkg::FOCAL_X_RST, ppp_pkg::FOCAL_Y_RST, ppp_pkg::CENTER_X_RST,
                ppp_pkg::CENTER_Y_RST, 64'h4000_0000_0000_0000, '0);
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    random_points(150);
    gaps_on = 1'b1;
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      load_camera(16'($urandom_range(1000, 12000)), 16'($urandom_range(1000, 12000)),
                  16'($urandom_range(0, 25000)), 16'($urandom_range(0, 16000)),
                  random_quat(), 48'({$urandom, $urandom}));
      gaps_on = (ph != 2);
      random_points(120);
      drain();
    end
    gaps_on = 1'b1;

    repeat (40) @(posedge clk);
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/ppp_pkg.sv
design/ppp_rot.sv
design/ppp_div.sv
design/pinhole_point_projector_core.sv
tb/testbench.sv
